// ----- rtl/obd_pkg.sv -----
// Shared types, rate-code constants and rate decode for the OFDM bit deinterleaver.
package obd_pkg;

    localparam int CBPS_W = 9;

    localparam logic [3:0] RATE_BPSK_A  = 4'd13;
    localparam logic [3:0] RATE_BPSK_B  = 4'd15;
    localparam logic [3:0] RATE_QPSK_A  = 4'd5;
    localparam logic [3:0] RATE_QPSK_B  = 4'd7;
    localparam logic [3:0] RATE_QAM16_A = 4'd9;
    localparam logic [3:0] RATE_QAM16_B = 4'd11;
    localparam logic [3:0] RATE_QAM64_A = 4'd1;
    localparam logic [3:0] RATE_QAM64_B = 4'd3;

    localparam logic [CBPS_W-1:0] NCBPS_BPSK  = 9'd48;
    localparam logic [CBPS_W-1:0] NCBPS_QPSK  = 9'd96;
    localparam logic [CBPS_W-1:0] NCBPS_QAM16 = 9'd192;
    localparam logic [CBPS_W-1:0] NCBPS_QAM64 = 9'd288;

    localparam logic [3:0] BYTE_BITS = 4'd8;

    typedef struct packed {
        logic [3:0] rate_code;
        logic [7:0] coded_byte;
        logic [3:0] valid_bits;
        logic       packet_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] plain_byte;
        logic [3:0] plain_bits;
        logic       run_last;
        logic       packet_done;
    } out_item_t;

    // s = max(NBPSC/2, 1)
    typedef struct packed {
        logic [1:0]        s;
        logic [CBPS_W-1:0] ncbps;
    } rate_cfg_t;

    typedef struct packed {
        logic clear;
        logic step;
    } idx_ctrl_t;

    function automatic rate_cfg_t rate_decode(input logic [3:0] code);
        rate_cfg_t cfg;
        unique case (code)
            RATE_BPSK_A, RATE_BPSK_B:
            begin
                cfg.s = 2'd1;
                cfg.ncbps = NCBPS_BPSK;
            end
            RATE_QAM16_A, RATE_QAM16_B:
            begin
                cfg.s = 2'd2;
                cfg.ncbps = NCBPS_QAM16;
            end
            RATE_QAM64_A, RATE_QAM64_B:
            begin
                cfg.s = 2'd3;
                cfg.ncbps = NCBPS_QAM64;
            end
            default:
            begin
                cfg.s = 2'd1;
                cfg.ncbps = NCBPS_QPSK;
            end
        endcase
        return cfg;
    endfunction

endpackage

// ----- rtl/obd_in_if.sv -----
// Input channel: interleaved coded bytes with rate code and packet marks.
interface obd_in_if;
    logic               valid;
    logic               ready;
    obd_pkg::in_item_t  item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ----- rtl/obd_out_if.sv -----
// Output channel: deinterleaved bytes with symbol and packet end marks.
interface obd_out_if;
    logic               valid;
    logic               ready;
    obd_pkg::out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ----- rtl/obd_symbol_ram.sv -----
// Single-bit symbol store, one write port and one registered read port.
module obd_symbol_ram #(
    parameter int DEPTH = 288
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic                     wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic                     rd_data
);

    logic mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/obd_index_unit.sv -----
// Source index generator: steps output position k and forms j(k) with one add/subtract.
module obd_index_unit #(
    parameter int MAX_SYMBOL_BITS = 288
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  obd_pkg::idx_ctrl_t                 ctrl,
    input  logic [$clog2(MAX_SYMBOL_BITS+1)-1:0] ncbps,
    input  logic [1:0]                         s,
    output logic [$clog2(MAX_SYMBOL_BITS)-1:0] src_idx
);

    localparam int AW = $clog2(MAX_SYMBOL_BITS);
    localparam int CW = $clog2(MAX_SYMBOL_BITS + 1);
    localparam int RW = $clog2(MAX_SYMBOL_BITS / 16);

    // i = (n/16)*col + row; i mod s == row mod s since (n/16) mod s == 0
    logic [AW-1:0] i_reg, i_next;
    logic [3:0]    col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [1:0]    rm_reg, rm_next;
    logic [1:0]    cm_reg, cm_next;
    logic [CW-5:0] m;
    logic [1:0]    d;
    logic [1:0]    rm_inc;
    logic [1:0]    cm_inc;

    assign m      = ncbps[CW-1:4];
    assign rm_inc = (2'(rm_reg + 2'd1) == s) ? 2'd0 : 2'(rm_reg + 2'd1);
    assign cm_inc = (2'(cm_reg + 2'd1) == s) ? 2'd0 : 2'(cm_reg + 2'd1);
    assign d      = (rm_reg >= cm_reg) ? 2'(rm_reg - cm_reg) : 2'(rm_reg + s - cm_reg);
    assign src_idx = AW'(i_reg - AW'(rm_reg) + AW'(d));

    always_comb
    begin
        i_next   = i_reg;
        col_next = col_reg;
        row_next = row_reg;
        rm_next  = rm_reg;
        cm_next  = cm_reg;
        priority if (ctrl.clear)
        begin
            i_next   = '0;
            col_next = '0;
            row_next = '0;
            rm_next  = '0;
            cm_next  = '0;
        end
        else if (ctrl.step)
        begin
            if (col_reg == 4'd15)
            begin
                col_next = '0;
                row_next = RW'(row_reg + 1'b1);
                rm_next  = rm_inc;
                cm_next  = '0;
                i_next   = AW'(row_reg + 1'b1);
            end
            else
            begin
                col_next = 4'(col_reg + 4'd1);
                cm_next  = cm_inc;
                i_next   = AW'(i_reg + AW'(m));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg   <= '0;
            col_reg <= '0;
            row_reg <= '0;
            rm_reg  <= '0;
            cm_reg  <= '0;
        end
        else
        begin
            i_reg   <= i_next;
            col_reg <= col_next;
            row_reg <= row_next;
            rm_reg  <= rm_next;
            cm_reg  <= cm_next;
        end
    end

endmodule

// ----- rtl/ofdm_bit_deinterleaver.sv -----
// Top level: OFDM bit deinterleaver with bit store, index unit and sequencer.
//
//  channel  dir  modport  transaction
//  coded    in   sink     one coded byte, rate code, valid bit count, packet end
//  plain    out  source   one deinterleaved byte, bit count, symbol/packet end
//
//  A transaction on coded writes its valid bits into the store in WRITE, one by one.
//  Emitting a symbol steps ADDR and DATA for each bit and OUT for each output byte;
//  the single-bit store is read once per bit through the index unit.
//  coded is not ready while a transaction is in work; plain stalls hold the
//  sequencer. Reset is asynchronous; the store needs no clearing.
module ofdm_bit_deinterleaver #(
    parameter int MAX_SYMBOL_BITS = 288
) (
    input  logic       clk,
    input  logic       rst_n,
    obd_in_if.sink     coded,
    obd_out_if.source  plain
);

    localparam int AW = $clog2(MAX_SYMBOL_BITS);
    localparam int CW = $clog2(MAX_SYMBOL_BITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_ADDR,
        ST_DATA,
        ST_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [7:0]         byte_reg, byte_next;
    logic [3:0]         vb_reg, vb_next;
    logic               end_reg, end_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [3:0]         held_rate_reg, held_rate_next;
    logic [CW-1:0]      nbits_reg, nbits_next;
    logic               last_reg, last_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [7:0]         acc_reg, acc_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic               jvalid_reg, jvalid_next;
    logic               out_valid_reg, out_valid_next;
    obd_pkg::out_item_t out_item_reg, out_item_next;

    obd_pkg::rate_cfg_t rcfg;
    obd_pkg::idx_ctrl_t idx_ctrl;
    logic [CW-1:0]      ncbps;
    logic [AW-1:0]      src_idx;
    logic [3:0]         vb_clamp;
    logic [CW-1:0]      fill_inc;
    logic [CW-1:0]      k_inc;
    logic [3:0]         cnt_inc;
    logic [7:0]         acc_new;
    logic               ram_we;
    logic               ram_re;
    logic               ram_rd;
    logic               bit_val;

    assign rcfg     = obd_pkg::rate_decode(held_rate_reg);
    assign ncbps    = CW'(rcfg.ncbps);
    assign vb_clamp = (coded.item.valid_bits > obd_pkg::BYTE_BITS) ? obd_pkg::BYTE_BITS
                                                                   : coded.item.valid_bits;
    assign fill_inc = CW'(fill_reg + 1'b1);
    assign k_inc    = CW'(k_reg + 1'b1);
    assign cnt_inc  = 4'(cnt_reg + 4'd1);
    assign bit_val  = ram_rd & jvalid_reg;
    assign acc_new  = acc_reg | (8'(bit_val) << cnt_reg[2:0]);

    assign coded.ready = (state_reg == ST_IDLE);
    assign plain.valid = out_valid_reg;
    assign plain.item  = out_item_reg;

    obd_symbol_ram #(
        .DEPTH (MAX_SYMBOL_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (byte_reg[0]),
        .rd_en   (ram_re),
        .rd_addr (src_idx),
        .rd_data (ram_rd)
    );

    obd_index_unit #(
        .MAX_SYMBOL_BITS (MAX_SYMBOL_BITS)
    ) u_idx (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (idx_ctrl),
        .ncbps   (ncbps),
        .s       (rcfg.s),
        .src_idx (src_idx)
    );

    always_comb
    begin
        state_next     = state_reg;
        byte_next      = byte_reg;
        vb_next        = vb_reg;
        end_next       = end_reg;
        fill_next      = fill_reg;
        held_rate_next = held_rate_reg;
        nbits_next     = nbits_reg;
        last_next      = last_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        jvalid_next    = jvalid_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        idx_ctrl       = '0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (coded.valid)
                begin
                    byte_next = coded.item.coded_byte;
                    vb_next   = vb_clamp;
                    end_next  = coded.item.packet_end;
                    if (fill_reg == '0 && vb_clamp != '0)
                    begin
                        held_rate_next = coded.item.rate_code;
                    end
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (vb_reg != '0)
                begin
                    ram_we    = 1'b1;
                    byte_next = byte_reg >> 1;
                    vb_next   = 4'(vb_reg - 4'd1);
                    fill_next = fill_inc;
                    if (fill_inc >= ncbps)
                    begin
                        nbits_next    = ncbps;
                        last_next     = end_reg;
                        fill_next     = '0;
                        idx_ctrl.clear = 1'b1;
                        k_next        = '0;
                        acc_next      = '0;
                        cnt_next      = '0;
                        state_next    = ST_ADDR;
                    end
                end
                else if (end_reg && fill_reg != '0)
                begin
                    nbits_next     = fill_reg;
                    last_next      = 1'b1;
                    fill_next      = '0;
                    idx_ctrl.clear = 1'b1;
                    k_next         = '0;
                    acc_next       = '0;
                    cnt_next       = '0;
                    state_next     = ST_ADDR;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ADDR:
            begin
                ram_re      = 1'b1;
                jvalid_next = (CW'(src_idx) < nbits_reg);
                state_next  = ST_DATA;
            end
            ST_DATA:
            begin
                idx_ctrl.step = 1'b1;
                k_next        = k_inc;
                acc_next      = acc_new;
                cnt_next      = cnt_inc;
                if (cnt_inc == obd_pkg::BYTE_BITS || k_inc == nbits_reg)
                begin
                    out_item_next.plain_byte  = acc_new;
                    out_item_next.plain_bits  = cnt_inc;
                    out_item_next.run_last    = (k_inc == nbits_reg);
                    out_item_next.packet_done = (k_inc == nbits_reg) && last_reg;
                    out_valid_next            = 1'b1;
                    state_next                = ST_OUT;
                end
                else
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_OUT:
            begin
                if (plain.ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_item_reg.run_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        acc_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_ADDR;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            byte_reg      <= '0;
            vb_reg        <= '0;
            end_reg       <= 1'b0;
            fill_reg      <= '0;
            held_rate_reg <= '0;
            nbits_reg     <= '0;
            last_reg      <= 1'b0;
            k_reg         <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            jvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_reg      <= byte_next;
            vb_reg        <= vb_next;
            end_reg       <= end_next;
            fill_reg      <= fill_next;
            held_rate_reg <= held_rate_next;
            nbits_reg     <= nbits_next;
            last_reg      <= last_next;
            k_reg         <= k_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            jvalid_reg    <= jvalid_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the OFDM bit deinterleaver: random packets, stalls, scoreboard.
module testbench;
    import obd_pkg::*;

    localparam int          SYM_MAX        = 288;
    localparam int unsigned CYCLE_LIMIT    = 1_500_000;
    localparam int unsigned DRAIN_CYCLES   = 700;
    localparam int unsigned RX_HOLD_CYCLES = 2500;
    localparam logic [3:0]  RATE_UNKNOWN   = 4'd0;

    class deint_scoreboard;
        bit [SYM_MAX-1:0] sym_store;
        int unsigned      fill_bits;
        logic [3:0]       symbol_rate;
        out_item_t        expected_q[$];
        int unsigned      failures;

        function new();
            sym_store = '0;
            fill_bits = 0;
            symbol_rate = '0;
            failures = 0;
        endfunction

        function int unsigned symbol_bits(logic [3:0] code);
            case (code)
                RATE_BPSK_A, RATE_BPSK_B:   return 32'(NCBPS_BPSK);
                RATE_QAM16_A, RATE_QAM16_B: return 32'(NCBPS_QAM16);
                RATE_QAM64_A, RATE_QAM64_B: return 32'(NCBPS_QAM64);
                default:                    return 32'(NCBPS_QPSK);
            endcase
        endfunction

        // s = max(bits per subcarrier / 2, 1)
        function int unsigned column_span(logic [3:0] code);
            case (code)
                RATE_QAM16_A, RATE_QAM16_B: return 2;
                RATE_QAM64_A, RATE_QAM64_B: return 3;
                default:                    return 1;
            endcase
        endfunction

        function int unsigned source_bit(int unsigned k, int unsigned n, int unsigned s);
            int unsigned i;
            i = (n / 16) * (k % 16) + k / 16;
            return s * (i / s) + (i + n - (16 * i) / n) % s;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10)
                $display("%s", msg);
        endfunction

        function void push_symbol(int unsigned n, int unsigned s, int unsigned nbits,
                                  bit pkt_last);
            bit [SYM_MAX-1:0] ordered;
            int unsigned      k, nbytes, b, t;
            out_item_t        res;
            ordered = '0;
            for (k = 0; k < n; k++)
                ordered[k] = sym_store[source_bit(k, n, s)];
            nbytes = (nbits + 7) / 8;
            for (b = 0; b < nbytes; b++)
            begin
                res = '0;
                for (t = 0; t < 8; t++)
                begin
                    if (b * 8 + t < nbits)
                    begin
                        res.plain_byte[t] = ordered[b * 8 + t];
                        res.plain_bits = res.plain_bits + 4'd1;
                    end
                end
                res.run_last = (b + 1 == nbytes);
                res.packet_done = (b + 1 == nbytes) && pkt_last;
                expected_q.push_back(res);
            end
        endfunction

        function void note_coded(in_item_t txn);
            int unsigned nbits, n, s, b, k;
            bit          full;
            nbits = (txn.valid_bits > 8) ? 8 : txn.valid_bits;
            if (fill_bits == 0 && nbits > 0)
                symbol_rate = txn.rate_code;
            n = symbol_bits(symbol_rate);
            s = column_span(symbol_rate);
            full = 1'b0;
            for (b = 0; b < nbits && !full; b++)
            begin
                sym_store[fill_bits] = txn.coded_byte[b];
                fill_bits++;
                if (fill_bits >= n)
                    full = 1'b1;
            end
            if (full)
            begin
                push_symbol(n, s, n, txn.packet_end);
                fill_bits = 0;
            end
            else if (txn.packet_end)
            begin
                if (fill_bits > 0)
                begin
                    for (k = fill_bits; k < n; k++)
                        sym_store[k] = 1'b0;
                    push_symbol(n, s, fill_bits, 1'b1);
                end
                fill_bits = 0;
            end
        endfunction

        function void check_plain(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                flag($sformatf("unexpected plain transaction: byte=%02h bits=%0d last=%0b done=%0b",
                               got.plain_byte, got.plain_bits, got.run_last, got.packet_done));
                return;
            end
            want = expected_q.pop_front();
            if (got.plain_byte !== want.plain_byte || got.plain_bits !== want.plain_bits ||
                got.run_last !== want.run_last || got.packet_done !== want.packet_done)
                flag($sformatf({"plain mismatch: exp byte=%02h bits=%0d last=%0b done=%0b, ",
                                "got byte=%02h bits=%0d last=%0b done=%0b"},
                               want.plain_byte, want.plain_bits, want.run_last, want.packet_done,
                               got.plain_byte, got.plain_bits, got.run_last, got.packet_done));
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    obd_in_if  coded();
    obd_out_if plain();

    ofdm_bit_deinterleaver dut (
        .clk   (clk),
        .rst_n (rst_n),
        .coded (coded),
        .plain (plain)
    );

    deint_scoreboard sb = new();

    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;
    bit          tx_idling = 1'b0;
    bit          rx_idling = 1'b0;
    bit          long_hold_req = 1'b0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (coded.valid && coded.ready)
                sb.note_coded(coded.item);
            if (plain.valid && plain.ready)
                sb.check_plain(plain.item);
        end
    end

    initial
    begin
        int unsigned gap_left, hold_left;
        bit          hold_taken;
        gap_left = 0;
        hold_left = 0;
        hold_taken = 1'b0;
        plain.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                plain.ready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                plain.ready <= 1'b0;
            end
            else if (rx_idling && $urandom_range(0, 5) == 0)
            begin
                gap_left = $urandom_range(0, 5);
                plain.ready <= 1'b0;
            end
            else
                plain.ready <= 1'b1;
        end
    end

    task automatic send_coded(input logic [3:0] rate, input logic [7:0] data,
                              input logic [3:0] nbits, input logic last);
        in_item_t txn;
        txn.rate_code = rate;
        txn.coded_byte = data;
        txn.valid_bits = nbits;
        txn.packet_end = last;
        coded.item <= txn;
        coded.valid <= 1'b1;
        @(posedge clk);
        while (!coded.ready)
            @(posedge clk);
        if (nbits != 0 || last)
            items_sent++;
        if (tx_idling && $urandom_range(0, 5) == 0)
        begin
            coded.valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    task automatic send_packet(input bit noisy, input bit wide);
        logic [3:0]  rate, r, nbits;
        logic        pe;
        int unsigned sel, nsym, nbytes, i;
        sel = $urandom_range(0, 9);
        if (wide || sel == 9)
            rate = $urandom_range(0, 1) ? RATE_QAM64_A : RATE_QAM64_B;
        else if (sel < 4)
            rate = $urandom_range(0, 1) ? RATE_BPSK_A : RATE_BPSK_B;
        else if (sel < 6)
            rate = $urandom_range(0, 1) ? RATE_QPSK_A : RATE_QPSK_B;
        else if (sel == 6)
            rate = 4'($urandom_range(0, 7) * 2);  // even codes decode as QPSK
        else
            rate = $urandom_range(0, 1) ? RATE_QAM16_A : RATE_QAM16_B;
        nsym = sb.symbol_bits(rate);
        if (wide)
            nbytes = $urandom_range(nsym / 8 + 1, nsym / 8 + 14);
        else if (noisy)
            nbytes = $urandom_range(1, 8);
        else
            nbytes = $urandom_range(1, nsym / 8 + nsym / 16 + 2);
        for (i = 0; i < nbytes; i++)
        begin
            r = rate;
            nbits = 4'd8;
            pe = (i + 1 == nbytes);
            if (pe)
                nbits = 4'($urandom_range(1, 8));
            if ($urandom_range(0, 9) == 0)
                nbits = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 7) == 0)
                r = 4'($urandom_range(0, 15));
            if (!pe && $urandom_range(0, 39) == 0)
                pe = 1'b1;
            if (noisy)
            begin
                r = 4'($urandom_range(0, 15));
                nbits = 4'($urandom_range(0, 15));
                pe = ($urandom_range(0, 3) == 0);
            end
            send_coded(r, 8'($urandom_range(0, 255)), nbits, pe);
        end
    endtask

    task automatic drain_all();
        coded.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned i;
        rst_n <= 1'b0;
        coded.valid <= 1'b0;
        coded.item <= '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idling = 1'b1;
        rx_idling <= 1'b1;

        // packet end on an empty store
        send_coded(RATE_QPSK_A, 8'h00, 4'd0, 1'b1);
        // BPSK symbol filled by the packet's last byte; rate code mid-symbol is ignored
        send_coded(RATE_BPSK_A, 8'hFF, 4'd8, 1'b0);
        send_coded(RATE_QAM64_A, 8'h00, 4'd8, 1'b0);
        send_coded(RATE_BPSK_A, 8'hA5, 4'd8, 1'b0);
        send_coded(RATE_BPSK_A, 8'h5A, 4'd8, 1'b0);
        send_coded(RATE_BPSK_A, 8'h01, 4'd8, 1'b0);
        send_coded(RATE_BPSK_A, 8'h80, 4'd8, 1'b1);
        // oversized bit count, then zero-bit byte flushing a partial 64QAM symbol
        send_coded(RATE_QAM64_B, 8'hFF, 4'd15, 1'b0);
        send_coded(RATE_QAM64_B, 8'h6C, 4'd3, 1'b0);
        send_coded(RATE_QAM64_B, 8'hFF, 4'd0, 1'b1);
        // symbol fills mid-byte, leftover bits dropped
        send_coded(RATE_BPSK_B, 8'h0F, 4'd4, 1'b0);
        for (i = 0; i < 5; i++)
            send_coded(RATE_BPSK_B, 8'($urandom_range(0, 255)), 4'd8, 1'b0);
        send_coded(RATE_BPSK_B, 8'hFF, 4'd8, 1'b0);
        send_coded(RATE_QPSK_B, 8'h7F, 4'd7, 1'b1);
        // zero-bit byte must not latch its rate
        send_coded(RATE_QAM16_A, 8'hFF, 4'd0, 1'b0);
        send_coded(RATE_QAM16_B, 8'h03, 4'd2, 1'b1);
        send_coded(RATE_UNKNOWN, 8'hC3, 4'd8, 1'b1);

        while (items_sent < 150)
            send_packet($urandom_range(0, 9) == 0, 1'b0);

        drain_all();

        // receiver holds off while the sender keeps pushing
        long_hold_req <= 1'b1;
        tx_idling = 1'b0;
        send_packet(1'b0, 1'b1);
        while (items_sent < 250)
            send_packet($urandom_range(0, 9) == 0, 1'b0);

        rx_idling <= 1'b0;
        while (items_sent < 320)
            send_packet($urandom_range(0, 9) == 0, 1'b0);

        tx_idling = 1'b1;
        rx_idling <= 1'b1;
        while (items_sent < 400)
            send_packet($urandom_range(0, 9) == 0, 1'b0);

        tx_idling = 1'b0;
        rx_idling <= 1'b0;
        while (items_sent < 470)
            send_packet($urandom_range(0, 9) == 0, 1'b0);

        drain_all();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- ofdm_bit_deinterleaver.f -----
rtl/obd_pkg.sv
rtl/obd_in_if.sv
rtl/obd_out_if.sv
rtl/obd_symbol_ram.sv
rtl/obd_index_unit.sv
rtl/ofdm_bit_deinterleaver.sv
verif/testbench.sv
